@@ hw/rtl/cse_pkg.sv @@
// shared sizes, state and opcode types, and controller/datapath signal groups
package cse_pkg;

   localparam int ELEM_BITS  = 16;
   localparam int MAX_LENGTH = 4096;

   // accumulator sizes: one square is at most 2^(2*ELEM_BITS-2)
   localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
   localparam int NORM_W = 2 * ELEM_BITS - 1 + $clog2(MAX_LENGTH);
   localparam int DOT_W  = NORM_W + 1;
   localparam int PROD_W = 2 * NORM_W;

   // result is Q1.15; the magnitude search runs one bit per round
   localparam int SIM_W  = 16;
   localparam int Q_W    = SIM_W;
   localparam int CMP_W  = PROD_W + 2 * SIM_W;
   localparam int STEP_W = $clog2(SIM_W);
   localparam int MCNT_W = $clog2(NORM_W);
   localparam int SH_W   = STEP_W + 2;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_PROD    = 8'b0000_0010,
      S_ADD_AB  = 8'b0000_0100,
      S_ADD_P   = 8'b0000_1000,
      S_SUB_B   = 8'b0001_0000,
      S_ADD_ONE = 8'b0010_0000,
      S_TEST    = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD_AB,
      OP_ADD_P,
      OP_SUB_B,
      OP_ADD_ONE,
      OP_TEST
   } op_type;

   typedef struct packed {
      logic              accept;
      logic              capture;
      logic              prod_step;
      op_type            op;
      logic [STEP_W-1:0] k;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/cse_channels.sv @@
// request and response channel interfaces
interface cse_req_if;
   import cse_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [ELEM_BITS-1:0] a_elem;
   logic signed [ELEM_BITS-1:0] b_elem;
   logic                        last;

   modport source (output valid, output a_elem, output b_elem, output last, input ready);
   modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface

interface cse_rsp_if;
   import cse_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SIM_W-1:0] similarity;
   logic                    zero_norm;
   logic                    overflow;

   modport source (output valid, output similarity, output zero_norm, output overflow,
                   input ready);
   modport sink   (input valid, input similarity, input zero_norm, input overflow,
                   output ready);
endinterface

@@ hw/rtl/cse_ctrl.sv @@
// sequencer for accumulation, norm products and the magnitude search
module cse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  cse_pkg::status_type  status,
   output cse_pkg::cmd_type     cmd
);
   import cse_pkg::*;

   state_type         state_ff, state_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic [STEP_W-1:0] k_ff, k_in;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      mcnt_in       = mcnt_ff;
      k_in          = k_ff;
      cmd.accept    = accept;
      cmd.capture   = accept && req_last;
      cmd.prod_step = 1'b0;
      cmd.op        = OP_NONE;
      cmd.k         = k_ff;
      cmd.load_out  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_last) begin
               state_in = S_PROD;
               mcnt_in  = MCNT_W'(NORM_W - 1);
            end
         end
         S_PROD: begin
            cmd.prod_step = 1'b1;
            if (status.zero) begin
               state_in = S_DONE;
            end else if (mcnt_ff == '0) begin
               state_in = S_ADD_AB;
               k_in     = STEP_W'(SIM_W - 1);
            end else begin
               mcnt_in = mcnt_ff - 1'b1;
            end
         end
         S_ADD_AB: begin
            cmd.op   = OP_ADD_AB;
            state_in = S_ADD_P;
         end
         S_ADD_P: begin
            cmd.op   = OP_ADD_P;
            state_in = S_SUB_B;
         end
         S_SUB_B: begin
            cmd.op   = OP_SUB_B;
            state_in = S_ADD_ONE;
         end
         S_ADD_ONE: begin
            cmd.op   = OP_ADD_ONE;
            state_in = S_TEST;
         end
         S_TEST: begin
            cmd.op = OP_TEST;
            if (k_ff == '0) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_ADD_AB;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mcnt_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         k_ff     <= k_in;
      end
   end

endmodule

@@ hw/rtl/cse_dpath.sv @@
// accumulators, serial norm products, magnitude search and result register
module cse_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cse_pkg::cmd_type                     cmd,
   input  logic signed [cse_pkg::ELEM_BITS-1:0] req_a_elem,
   input  logic signed [cse_pkg::ELEM_BITS-1:0] req_b_elem,
   input  logic                                 req_last,
   input  logic                                 rsp_ready,
   output cse_pkg::status_type                  status,
   output logic                                 rsp_valid,
   output logic signed [cse_pkg::SIM_W-1:0]     rsp_similarity,
   output logic                                 rsp_zero_norm,
   output logic                                 rsp_overflow
);
   import cse_pkg::*;

   // accumulation
   logic signed [DOT_W-1:0]       dot_ff, dot_in, dot_nx;
   logic [NORM_W-1:0]             na_ff, na_in, na_nx;
   logic [NORM_W-1:0]             nb_ff, nb_in, nb_nx;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          ovf_ff, ovf_in, ovf_nx;
   logic signed [2*ELEM_BITS-1:0] ab_prod, aa_prod, bb_prod;
   logic                          below_max;

   // captured operands
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              ovf_cap_ff, ovf_cap_in;
   logic [NORM_W-1:0] mag;

   // bit-serial products
   logic [PROD_W-1:0] p_mcand_ff, p_mcand_in, p_ff, p_in;
   logic [NORM_W-1:0] p_mplier_ff, p_mplier_in;
   logic [PROD_W-1:0] d_mcand_ff, d_mcand_in, d_ff, d_in;
   logic [NORM_W-1:0] d_mplier_ff, d_mplier_in;

   // search
   logic [CMP_W-1:0] a_ff, a_in, b_ff, b_in, ac_ff, ac_in, bc_ff, bc_in, l_ff, l_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CMP_W-1:0] p_ext, r_val;
   logic [SH_W-1:0]  sh1, sh2, sh3;
   logic             take;

   // result
   logic                    valid_ff, valid_in;
   logic signed [SIM_W-1:0] sim_ff, sim_in;
   logic                    zout_ff, zout_in;
   logic                    oout_ff, oout_in;
   logic [Q_W-1:0]          q_neg;

   assign ab_prod   = req_a_elem * req_b_elem;
   assign aa_prod   = req_a_elem * req_a_elem;
   assign bb_prod   = req_b_elem * req_b_elem;
   assign below_max = (cnt_ff < CNT_W'(MAX_LENGTH));

   always_comb begin
      dot_nx = dot_ff;
      na_nx  = na_ff;
      nb_nx  = nb_ff;
      ovf_nx = ovf_ff;
      if (below_max) begin
         dot_nx = dot_ff + DOT_W'(ab_prod);
         na_nx  = na_ff + NORM_W'(unsigned'(aa_prod));
         nb_nx  = nb_ff + NORM_W'(unsigned'(bb_prod));
      end else begin
         ovf_nx = 1'b1;
      end
      mag = dot_nx[DOT_W-1] ? NORM_W'(-dot_nx) : NORM_W'(dot_nx);
   end

   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.accept) begin
         if (req_last) begin
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            dot_in = dot_nx;
            na_in  = na_nx;
            nb_in  = nb_nx;
            ovf_in = ovf_nx;
            if (below_max) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      neg_in      = neg_ff;
      zero_in     = zero_ff;
      ovf_cap_in  = ovf_cap_ff;
      p_mcand_in  = p_mcand_ff;
      p_mplier_in = p_mplier_ff;
      p_in        = p_ff;
      d_mcand_in  = d_mcand_ff;
      d_mplier_in = d_mplier_ff;
      d_in        = d_ff;
      if (cmd.capture) begin
         neg_in      = dot_nx[DOT_W-1];
         zero_in     = (na_nx == '0) || (nb_nx == '0);
         ovf_cap_in  = ovf_nx;
         p_mcand_in  = PROD_W'(na_nx);
         p_mplier_in = nb_nx;
         p_in        = '0;
         d_mcand_in  = PROD_W'(mag);
         d_mplier_in = mag;
         d_in        = '0;
      end else if (cmd.prod_step) begin
         if (p_mplier_ff[0]) begin
            p_in = p_ff + p_mcand_ff;
         end
         if (d_mplier_ff[0]) begin
            d_in = d_ff + d_mcand_ff;
         end
         p_mcand_in  = p_mcand_ff << 1;
         p_mplier_in = p_mplier_ff >> 1;
         d_mcand_in  = d_mcand_ff << 1;
         d_mplier_in = d_mplier_ff >> 1;
      end
   end

   // A = 4q^2 P and B = 4q P; trial c = q + 2^k tests (2c-1)^2 P <= D^2 2^32
   assign p_ext = CMP_W'(p_ff);
   assign r_val = {d_ff, {(2 * SIM_W){1'b0}}};
   assign sh1   = SH_W'(cmd.k) + SH_W'(1);
   assign sh2   = SH_W'(cmd.k) + SH_W'(2);
   assign sh3   = (SH_W'(cmd.k) << 1) + SH_W'(2);
   assign take  = !q_ff[Q_W-1] && (l_ff <= r_val);

   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      ac_in = ac_ff;
      bc_in = bc_ff;
      l_in  = l_ff;
      q_in  = q_ff;
      if (cmd.capture) begin
         a_in = '0;
         b_in = '0;
         q_in = '0;
      end else begin
         case (cmd.op)
            OP_ADD_AB: begin
               ac_in = a_ff + (b_ff << sh1);
               bc_in = b_ff + (p_ext << sh2);
            end
            OP_ADD_P: begin
               ac_in = ac_ff + (p_ext << sh3);
            end
            OP_SUB_B: begin
               l_in = ac_ff - bc_ff;
            end
            OP_ADD_ONE: begin
               l_in = l_ff + p_ext;
            end
            OP_TEST: begin
               if (take) begin
                  a_in = ac_ff;
                  b_in = bc_ff;
                  q_in = q_ff | (Q_W'(1) << cmd.k);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign q_neg = Q_W'(0) - q_ff;

   always_comb begin
      valid_in = valid_ff;
      sim_in   = sim_ff;
      zout_in  = zout_ff;
      oout_in  = oout_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
         zout_in  = zero_ff;
         oout_in  = ovf_cap_ff;
         if (zero_ff) begin
            sim_in = '0;
         end else if (neg_ff) begin
            sim_in = signed'(SIM_W'(q_neg));
         end else if (q_ff[Q_W-1]) begin
            sim_in = signed'({1'b0, {(SIM_W - 1){1'b1}}});
         end else begin
            sim_in = signed'(SIM_W'(q_ff));
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         na_ff    <= '0;
         nb_ff    <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         dot_ff   <= dot_in;
         na_ff    <= na_in;
         nb_ff    <= nb_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      ovf_cap_ff  <= ovf_cap_in;
      p_mcand_ff  <= p_mcand_in;
      p_mplier_ff <= p_mplier_in;
      p_ff        <= p_in;
      d_mcand_ff  <= d_mcand_in;
      d_mplier_ff <= d_mplier_in;
      d_ff        <= d_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ac_ff       <= ac_in;
      bc_ff       <= bc_in;
      l_ff        <= l_in;
      q_ff        <= q_in;
      sim_ff      <= sim_in;
      zout_ff     <= zout_in;
      oout_ff     <= oout_in;
   end

   assign status.zero     = zero_ff;
   assign status.out_free = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_similarity = sim_ff;
   assign rsp_zero_norm  = zout_ff;
   assign rsp_overflow   = oout_ff;

endmodule

@@ hw/rtl/cosine_similarity_engine.sv @@
// element pairs: one transfer per cycle; a last pair holds req ready low until its result
// is registered; it runs the bit-serial norm products, then one search round per result
// bit of adder passes (A+B, P, -B, +1, test), then the load; a zero norm skips the search
// a result waits in the output register while new pairs keep streaming in
// synchronous reset clears accumulators, count, overflow flag, sequencer and rsp valid
module cosine_similarity_engine (
   input logic       clock,
   input logic       reset,
   cse_req_if.sink   req_ch,
   cse_rsp_if.source rsp_ch
);
   import cse_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accumulate, multiply norms, run the magnitude search, hand off result
   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: running sums, serial products, bit-by-bit quotient, output register
   cse_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_a_elem     (req_ch.a_elem),
      .req_b_elem     (req_ch.b_elem),
      .req_last       (req_ch.last),
      .rsp_ready      (rsp_ch.ready),
      .status         (status),
      .rsp_valid      (rsp_ch.valid),
      .rsp_similarity (rsp_ch.similarity),
      .rsp_zero_norm  (rsp_ch.zero_norm),
      .rsp_overflow   (rsp_ch.overflow)
   );

`ifndef SYNTH
   // a last transfer always starts the final computation
   last_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.last) |=> !req_ch.ready)
      else $error("input still ready after last transfer");

   // a zero norm always reports a similarity of zero
   zero_norm_clears_sim: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.zero_norm) |-> (rsp_ch.similarity == '0))
      else $error("zero norm with nonzero similarity");

   // a new result only follows the final computation, never an open input
   result_after_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> !$past(req_ch.ready))
      else $error("result appeared while input was open");

   // reset drops any pending result
   reset_drops_result: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid after reset");
`endif

endmodule
